>>> sv/msde_pkg.sv
// ----------------------------------------------------------------------------
// msde_pkg
// Shared types, constants and header decode tables for the duration estimator.
// ----------------------------------------------------------------------------
package msde_pkg;

	localparam int NUM_W = 44;
	localparam int DEN_W = 20;
	localparam int DUR_W = 30;
	localparam int JOB_DEPTH = 2;

	localparam logic [31:0] SYNC_MASK = 32'hffe00000;
	localparam logic [31:0] TAG_XING = 32'h58696e67;
	localparam logic [31:0] TAG_INFO = 32'h496e666f;
	localparam logic [23:0] ID3_MAGIC = 24'h494433;
	localparam logic [1:0] VER_MPEG1 = 2'd3;
	localparam logic [1:0] VER_MPEG2 = 2'd2;
	localparam logic [1:0] VER_MPEG25 = 2'd0;
	localparam logic [1:0] LAYER_III = 2'd1;
	localparam logic [1:0] CH_MONO = 2'd3;
	localparam logic [10:0] SPF_LONG = 11'd1152;
	localparam logic [10:0] SPF_SHORT = 11'd576;
	localparam logic [9:0] RATE_SCALE = 10'd1000;
	localparam logic [8:0] RATE_HALF = 9'd500;
	localparam int MIN_BYTES = 128;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_ID3,
		PH_SEARCH,
		PH_TAG,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		JM_ZERO,
		JM_XING,
		JM_RATE
	} job_mode_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOAD,
		BK_DIV,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		job_mode_t mode;
		logic found;
		logic [31:0] count;
		logic long_frames;
		logic [15:0] srate;
		logic [31:0] bytes;
		logic [8:0] bitrate;
	} job_t;

	typedef struct packed {
		logic [DUR_W-1:0] duration;
		logic found;
		logic xing;
	} result_t;

	function automatic logic [8:0] header_kbps(input logic [1:0] ver, input logic [1:0] layer,
			input logic [3:0] idx);
		logic [8:0] v;
		v = 9'd0;
		if (layer == LAYER_III) begin
			if (ver == VER_MPEG1) begin
				unique case (idx)
					4'd1: v = 9'd32;
					4'd2: v = 9'd40;
					4'd3: v = 9'd48;
					4'd4: v = 9'd56;
					4'd5: v = 9'd64;
					4'd6: v = 9'd80;
					4'd7: v = 9'd96;
					4'd8: v = 9'd112;
					4'd9: v = 9'd128;
					4'd10: v = 9'd160;
					4'd11: v = 9'd192;
					4'd12: v = 9'd224;
					4'd13: v = 9'd256;
					4'd14: v = 9'd320;
					default: v = 9'd0;
				endcase
			end else begin
				unique case (idx)
					4'd1: v = 9'd8;
					4'd2: v = 9'd16;
					4'd3: v = 9'd24;
					4'd4: v = 9'd32;
					4'd5: v = 9'd40;
					4'd6: v = 9'd48;
					4'd7: v = 9'd56;
					4'd8: v = 9'd64;
					4'd9: v = 9'd80;
					4'd10: v = 9'd96;
					4'd11: v = 9'd112;
					4'd12: v = 9'd128;
					4'd13: v = 9'd144;
					4'd14: v = 9'd160;
					default: v = 9'd0;
				endcase
			end
		end
		return v;
	endfunction

	function automatic logic [15:0] header_rate(input logic [1:0] ver, input logic [1:0] sidx);
		logic [15:0] v;
		v = 16'd0;
		unique case (ver)
			VER_MPEG1: begin
				unique case (sidx)
					2'd0: v = 16'd44100;
					2'd1: v = 16'd48000;
					2'd2: v = 16'd32000;
					default: v = 16'd0;
				endcase
			end
			VER_MPEG2: begin
				unique case (sidx)
					2'd0: v = 16'd22050;
					2'd1: v = 16'd24000;
					2'd2: v = 16'd16000;
					default: v = 16'd0;
				endcase
			end
			VER_MPEG25: begin
				unique case (sidx)
					2'd0: v = 16'd11025;
					2'd1: v = 16'd12000;
					2'd2: v = 16'd8000;
					default: v = 16'd0;
				endcase
			end
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

>>> sv/msde_front.sv
// ----------------------------------------------------------------------------
// msde_front
// Byte scanner: ID3 skip, frame header search and Xing/Info tag parse.
// ----------------------------------------------------------------------------
module msde_front import msde_pkg::*; #(
	parameter int SEARCH_WINDOW = 65536,
	parameter int POSITION_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [31:0] file_length,
	output logic        job_valid,
	output job_t        job
);

	localparam int W = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 2;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [31:0] recent_q, recent_d;
	logic [W-1:0] start_q, start_d;
	phase_t phase_q, phase_d;
	logic [POSITION_BITS-1:0] fpos_q, fpos_d;
	logic [8:0] br_q, br_d;
	logic [15:0] sr_q, sr_d;
	logic [W-1:0] tpos_q, tpos_d;
	logic long_q, long_d;
	logic [31:0] flags_q, flags_d;
	logic [31:0] count_q, count_d;
	logic seen_q, seen_d;

	logic [W-1:0] p_w, fl_w, off_w, rel_w, fpos_w;
	logic in_file;
	logic [8:0] h_br;
	logic [15:0] h_sr;
	logic [15:0] half_up;
	logic [17:0] small_prod;
	logic [10:0] spf;

	always_comb begin
		p_w = W'(pos_q);
		fl_w = W'(file_length);
		off_w = p_w - W'(3);
		rel_w = p_w - tpos_q;
		in_file = (p_w < fl_w) && (pos_q != POS_MAX);
		recent_d = {recent_q[23:0], data_byte};
		h_br = header_kbps(recent_d[20:19], recent_d[18:17], recent_d[15:12]);
		h_sr = header_rate(recent_d[20:19], recent_d[11:10]);
		spf = long_q ? SPF_LONG : SPF_SHORT;
		half_up = sr_q - (sr_q >> 1);
		small_prod = 18'(recent_d[6:0]) * 18'(spf);
	end

	always_comb begin
		pos_d = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
		start_d = start_q;
		phase_d = phase_q;
		fpos_d = fpos_q;
		br_d = br_q;
		sr_d = sr_q;
		tpos_d = tpos_q;
		long_d = long_q;
		flags_d = flags_q;
		count_d = count_q;
		seen_d = seen_q;
		unique case (phase_q)
			PH_HEAD: begin
				if (p_w == W'(2)) begin
					if (recent_d[23:0] == ID3_MAGIC && file_length >= 32'd10) begin
						phase_d = PH_ID3;
					end else begin
						start_d = '0;
						phase_d = PH_SEARCH;
					end
				end
			end
			PH_ID3: begin
				if (p_w == W'(9)) begin
					start_d = W'({recent_d[30:24], recent_d[22:16], recent_d[14:8],
						recent_d[6:0]}) + W'(10);
					phase_d = PH_SEARCH;
				end
			end
			PH_SEARCH: begin
				if (p_w >= W'(3) && in_file && (p_w + W'(1)) < fl_w && off_w >= start_q
						&& off_w < start_q + W'(SEARCH_WINDOW)
						&& (recent_d & SYNC_MASK) == SYNC_MASK && h_br != 9'd0
						&& h_sr != 16'd0) begin
					fpos_d = off_w[POSITION_BITS-1:0];
					br_d = h_br;
					sr_d = h_sr;
					long_d = (recent_d[20:19] == VER_MPEG1);
					if (recent_d[20:19] == VER_MPEG1)
						tpos_d = off_w + ((recent_d[7:6] == CH_MONO) ? W'(21) : W'(36));
					else
						tpos_d = off_w + ((recent_d[7:6] == CH_MONO) ? W'(13) : W'(21));
					phase_d = PH_TAG;
				end
			end
			PH_TAG: begin
				if (p_w >= tpos_q) begin
					if (!in_file) begin
						phase_d = PH_DONE;
					end else if (rel_w == W'(3)) begin
						if (recent_d != TAG_XING && recent_d != TAG_INFO) phase_d = PH_DONE;
					end else if (rel_w == W'(7)) begin
						flags_d = recent_d;
						if (!recent_d[0]) phase_d = PH_DONE;
					end else if (rel_w == W'(11)) begin
						count_d = recent_d;
						if (recent_d != 32'd0 && sr_q != 16'd0)
							seen_d = (recent_d >= 32'd84) || (small_prod >= 18'(half_up));
						phase_d = PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		fpos_w = W'(fpos_d);
		job.found = (phase_d == PH_TAG) || (phase_d == PH_DONE);
		job.count = count_d;
		job.long_frames = long_d;
		job.srate = sr_d;
		job.bitrate = br_d;
		job.bytes = 32'(fl_w - fpos_w);
		if (!job.found)
			job.mode = JM_ZERO;
		else if (seen_d)
			job.mode = JM_XING;
		else if (fl_w > fpos_w && (fl_w - fpos_w) > W'(MIN_BYTES))
			job.mode = JM_RATE;
		else
			job.mode = JM_ZERO;
		job_valid = accept && last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			recent_q <= '0;
			start_q <= '0;
			phase_q <= PH_HEAD;
			fpos_q <= '0;
			br_q <= '0;
			sr_q <= '0;
			tpos_q <= '0;
			long_q <= 1'b0;
			flags_q <= '0;
			count_q <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0;
				recent_q <= '0;
				start_q <= '0;
				phase_q <= PH_HEAD;
				fpos_q <= '0;
				br_q <= '0;
				sr_q <= '0;
				tpos_q <= '0;
				long_q <= 1'b0;
				flags_q <= '0;
				count_q <= '0;
				seen_q <= 1'b0;
			end else begin
				pos_q <= pos_d;
				recent_q <= recent_d;
				start_q <= start_d;
				phase_q <= phase_d;
				fpos_q <= fpos_d;
				br_q <= br_d;
				sr_q <= sr_d;
				tpos_q <= tpos_d;
				long_q <= long_d;
				flags_q <= flags_d;
				count_q <= count_d;
				seen_q <= seen_d;
			end
		end
	end

endmodule

>>> sv/msde_queue.sv
// ----------------------------------------------------------------------------
// msde_queue
// Short job queue between the byte scanner and the divider.
// ----------------------------------------------------------------------------
module msde_queue import msde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output job_t rd_job
);

	localparam int PTR_W = $clog2(JOB_DEPTH);

	job_t mem_q [JOB_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0] cnt_q;

	assign full = (cnt_q == (PTR_W+1)'(JOB_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_job = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !full) wptr_q <= wptr_q + 1'b1;
			if (rd_en && rd_valid) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (PTR_W+1)'(wr_en && !full) - (PTR_W+1)'(rd_en && rd_valid);
		end
	end

endmodule

>>> sv/msde_back.sv
// ----------------------------------------------------------------------------
// msde_back
// Rounded duration divide, one quotient bit per cycle, into the result register.
// ----------------------------------------------------------------------------
module msde_back import msde_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    job_take,
	output logic    res_valid,
	output result_t res,
	input  logic    res_take
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	back_state_t state_q, state_d;
	job_t job_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0] rem_sh;
	logic out_valid_q;
	result_t out_q;

	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (job_valid) state_d = BK_LOAD;
			BK_LOAD: state_d = (job_q.mode == JM_ZERO) ? BK_OUT : BK_DIV;
			BK_DIV: if (cnt_q == CNT_W'(NUM_W - 1)) state_d = BK_OUT;
			BK_OUT: if (!out_valid_q || res_take) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_take = (state_q == BK_IDLE) && job_valid;
		res_valid = out_valid_q;
		res = out_q;
	end

	always_ff @(posedge clk) begin
		if (job_take) job_q <= job;
		unique case (state_q)
			BK_LOAD: begin
				rem_q <= '0;
				if (job_q.mode == JM_XING) begin
					num_q <= NUM_W'(job_q.count) * NUM_W'(job_q.long_frames ? SPF_LONG
						: SPF_SHORT) + NUM_W'(job_q.srate >> 1);
					den_q <= DEN_W'(job_q.srate);
				end else begin
					num_q <= (NUM_W'(job_q.bytes) << 3) + NUM_W'(job_q.bitrate) * NUM_W'(RATE_HALF);
					den_q <= DEN_W'(job_q.bitrate) * DEN_W'(RATE_SCALE);
				end
			end
			BK_DIV: begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					num_q <= {num_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					num_q <= {num_q[NUM_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
		if (state_q == BK_OUT && (!out_valid_q || res_take)) begin
			out_q.found <= job_q.found;
			out_q.xing <= (job_q.mode == JM_XING);
			out_q.duration <= (job_q.mode == JM_ZERO) ? '0 : num_q[DUR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= (state_q == BK_DIV) ? cnt_q + 1'b1 : '0;
			if (state_q == BK_OUT && (!out_valid_q || res_take))
				out_valid_q <= 1'b1;
			else if (res_take)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/mp3_stream_duration_estimator.sv
// ----------------------------------------------------------------------------
// mp3_stream_duration_estimator
// MP3 duration estimate from the file byte stream: scanner, job queue, divider.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while full is low. With the divider and the
// result register free, the result for a file passes from the job queue
// through the job register, the load state and the bit-serial 44-bit divider
// into the result register; a file for which no frame or estimate applies
// skips the divide. Two finished files can wait in the job queue, so the
// scanner keeps accepting bytes while the divider and the result register
// drain; full rises only if both queue slots hold files not yet started.
module mp3_stream_duration_estimator import msde_pkg::*; #(
	parameter int SEARCH_WINDOW = 65536,
	parameter int POSITION_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              empty,
	input  logic              pop,
	output logic [DUR_W-1:0]  play_secs,
	output logic              frame_found,
	output logic              from_xing,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);

	logic [31:0] file_length_q;
	logic accept;
	logic fj_valid, bk_take, q_valid, res_valid;
	job_t fj, qj;
	result_t res;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) file_length_q <= '0;
		else if (cfg_we) file_length_q <= cfg_wdata;
	end

	msde_front #(.SEARCH_WINDOW(SEARCH_WINDOW), .POSITION_BITS(POSITION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .data_byte(data_byte),
		.last_byte(last_byte), .file_length(file_length_q), .job_valid(fj_valid), .job(fj)
	);

	msde_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(fj_valid), .wr_job(fj), .full(full),
		.rd_en(bk_take), .rd_valid(q_valid), .rd_job(qj)
	);

	msde_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(q_valid), .job(qj), .job_take(bk_take),
		.res_valid(res_valid), .res(res), .res_take(pop && res_valid)
	);

	assign empty = !res_valid;
	assign play_secs = res.duration;
	assign frame_found = res.found;
	assign from_xing = res.xing;

endmodule

>>> sv/msde_checker.sv
// ----------------------------------------------------------------------------
// msde_checker
// Port-level checks on the result side of the duration estimator.
// ----------------------------------------------------------------------------
module msde_checker import msde_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic [DUR_W-1:0] play_secs,
	input logic             frame_found,
	input logic             from_xing
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(play_secs) && $stable(frame_found)
			&& $stable(from_xing)))
		else $error("pending result changed");

	a_xing_found: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && from_xing) |-> frame_found)
		else $error("xing result without frame");

	a_nofr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !frame_found) |-> (play_secs == '0))
		else $error("nonzero duration without frame");

	a_xing_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && from_xing) |-> (play_secs != '0))
		else $error("xing duration is zero");

endmodule

bind mp3_stream_duration_estimator msde_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.play_secs(play_secs), .frame_found(frame_found), .from_xing(from_xing)
);

>>> dv/tb_mp3_stream_duration_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mp3_stream_duration_estimator
// Streams synthetic MP3 files (ID3v2 prefix, junk, Layer III header, Xing/Info
// tag, trailer) into the estimator with random push and pop gaps, predicts
// the duration of each file and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_mp3_stream_duration_estimator;
	import msde_pkg::*;

	localparam longint unsigned WINDOW = 65536;
	localparam longint unsigned POS_MAX = 64'hffffffff;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [DUR_W-1:0] duration;
		logic found;
		logic xing;
	} estimate_t;

	localparam logic [8:0] KBPS_V1 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
		224, 256, 320, 0};
	localparam logic [8:0] KBPS_V2 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112,
		128, 144, 160, 0};
	localparam logic [15:0] RATE_V1 [4] = '{44100, 48000, 32000, 0};

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] data_byte;
	logic last_byte;
	logic empty;
	logic pop;
	logic [DUR_W-1:0] play_secs;
	logic frame_found;
	logic from_xing;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	estimate_t pending_q[$];
	logic [7:0] file_q[$];
	int errors;
	bit calm;
	int stall_left;

	// predictor state
	logic [31:0] len_reg;
	longint unsigned pos, audio_start, frame_pos, tag_pos;
	logic [31:0] recent, tag_count;
	phase_t ph;
	logic [8:0] kbps;
	logic [15:0] rate;
	bit long_frames, tag_ok;

	mp3_stream_duration_estimator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.play_secs(play_secs),
		.frame_found(frame_found),
		.from_xing(from_xing),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic clear_file_state();
		pos = 0; recent = 0; audio_start = 0; ph = PH_HEAD; frame_pos = 0; tag_pos = 0;
		kbps = 0; rate = 0; long_frames = 0; tag_count = 0; tag_ok = 0;
	endtask

	task automatic decode_header(longint unsigned off, logic [31:0] h);
		logic [1:0] ver, sidx;
		logic [8:0] br;
		logic [15:0] sr;
		if ((h & SYNC_MASK) != SYNC_MASK) return;
		ver = h[20:19];
		sidx = h[11:10];
		br = 0;
		if (h[18:17] == LAYER_III)
			br = (ver == VER_MPEG1) ? KBPS_V1[h[15:12]] : KBPS_V2[h[15:12]];
		sr = 0;
		if (ver == VER_MPEG1) sr = RATE_V1[sidx];
		else if (ver == VER_MPEG2) sr = RATE_V1[sidx] / 2;
		else if (ver == VER_MPEG25) sr = RATE_V1[sidx] / 4;
		if (br == 0 || sr == 0) return;
		frame_pos = off;
		kbps = br;
		rate = sr;
		long_frames = (ver == VER_MPEG1);
		if (ver == VER_MPEG1) tag_pos = off + 4 + ((h[7:6] == CH_MONO) ? 17 : 32);
		else tag_pos = off + 4 + ((h[7:6] == CH_MONO) ? 9 : 17);
		ph = PH_TAG;
	endtask

	task automatic estimate_byte(logic [7:0] d, bit is_last);
		bit in_file;
		longint unsigned rel, spf, sr, nbytes, br, q;
		estimate_t e;
		in_file = pos < len_reg && pos < POS_MAX;
		recent = {recent[23:0], d};
		spf = long_frames ? 1152 : 576;
		case (ph)
			PH_HEAD: if (pos == 2) begin
				if (recent[23:0] == ID3_MAGIC && len_reg >= 10) ph = PH_ID3;
				else begin
					audio_start = 0;
					ph = PH_SEARCH;
				end
			end
			PH_ID3: if (pos == 9) begin
				audio_start = 10 + {recent[30:24], recent[22:16], recent[14:8], recent[6:0]};
				ph = PH_SEARCH;
			end
			PH_SEARCH: if (pos >= 3 && in_file && pos + 1 < len_reg) begin
				if (pos - 3 >= audio_start && pos - 3 < audio_start + WINDOW)
					decode_header(pos - 3, recent);
			end
			PH_TAG: if (pos >= tag_pos) begin
				rel = pos - tag_pos;
				if (!in_file) ph = PH_DONE;
				else if (rel == 3) begin
					if (recent != TAG_XING && recent != TAG_INFO) ph = PH_DONE;
				end else if (rel == 7) begin
					if (!recent[0]) ph = PH_DONE;
				end else if (rel == 11) begin
					tag_count = recent;
					if (tag_count != 0 && rate != 0)
						tag_ok = ((tag_count * spf + rate / 2) / rate) > 0;
					ph = PH_DONE;
				end
			end
			default: ;
		endcase
		if (pos < POS_MAX) pos++;
		if (!is_last) return;
		e = '{default: 0};
		if (ph == PH_TAG || ph == PH_DONE) begin
			e.found = 1;
			if (tag_ok) begin
				sr = rate ? rate : 1;
				q = (tag_count * spf + sr / 2) / sr;
				e.duration = q[DUR_W-1:0];
				e.xing = 1;
			end else if (len_reg > frame_pos) begin
				nbytes = len_reg - frame_pos;
				br = kbps ? kbps : 1;
				if (nbytes > MIN_BYTES) begin
					q = (nbytes * 8 + br * 500) / (br * 1000);
					e.duration = q[DUR_W-1:0];
				end
			end
		end
		pending_q.push_back(e);
		clear_file_state();
	endtask

	task automatic send_byte(logic [7:0] d, bit is_last);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		data_byte <= d;
		last_byte <= is_last;
		do @(posedge clk); while (full);
		estimate_byte(d, is_last);
	endtask

	task automatic send_file();
		foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(logic [31:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		len_reg = v;
	endtask

	task automatic push_word(logic [31:0] w);
		for (int i = 3; i >= 0; i--) file_q.push_back(w[i*8 +: 8]);
	endtask

	// ver < 0 picks at random; tag_kind: 0 none, 1 Xing, 2 Info, 3 garbage
	task automatic build_file(int ver, int tag_kind, bit id3);
		logic [1:0] v, ch;
		int side, n;
		file_q.delete();
		if (id3) begin
			n = $urandom_range(0, 30);
			file_q.push_back("I"); file_q.push_back("D"); file_q.push_back("3");
			repeat (3) file_q.push_back(8'($urandom));
			push_word({4'h0, 28'(n)} | ($urandom & 32'h80808080));
			repeat (n) file_q.push_back(8'($urandom));
		end
		repeat ($urandom_range(0, 6)) file_q.push_back(8'($urandom_range(0, 254)));
		if (ver < 0) begin
			n = $urandom_range(0, 9);
			v = n < 5 ? VER_MPEG1 : n < 7 ? VER_MPEG2 : n < 9 ? VER_MPEG25 : 2'd1;
		end else v = 2'(ver);
		ch = 2'($urandom);
		file_q.push_back(8'hff);
		file_q.push_back({3'b111, v, ($urandom_range(0, 9) == 0) ? 2'($urandom) : LAYER_III,
			1'($urandom)});
		file_q.push_back({4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), 2'($urandom)});
		file_q.push_back({ch, 6'($urandom)});
		side = (v == VER_MPEG1) ? ((ch == CH_MONO) ? 17 : 32) : ((ch == CH_MONO) ? 9 : 17);
		repeat (side) file_q.push_back(8'($urandom));
		if (tag_kind != 0) begin
			push_word(tag_kind == 1 ? TAG_XING : tag_kind == 2 ? TAG_INFO : $urandom);
			push_word($urandom_range(0, 3) == 0 ? $urandom : ($urandom | 32'h1));
			n = $urandom_range(0, 3);
			push_word(n == 0 ? 0 : n == 1 ? $urandom_range(1, 40) : $urandom);
		end
		repeat ($urandom_range(0, 12)) file_q.push_back(8'($urandom));
		if ($urandom_range(0, 6) == 0) file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
	endtask

	function automatic logic [31:0] pick_length(int sz);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, sz);
			1: return sz + $urandom_range(1, 2000000);
			2: return 32'hffffffff;
			3: return $urandom_range(sz > 12 ? sz - 12 : 0, sz);
			default: return sz;
		endcase
	endfunction

	task automatic test_short_files();
		write_length(0);
		file_q = '{8'hff};
		send_file();
		file_q = '{8'hff, 8'hfb, 8'h90, 8'h00};
		send_file();
		write_length(9);
		file_q = '{"I", "D", "3", 0, 0, 0, 0, 0, 0};
		send_file();
		write_length(3);
		file_q = '{"I", "D", "3"};
		send_file();
	endtask

	task automatic test_header_variants();
		for (int i = 0; i < 4; i++) begin
			build_file(i == 0 ? VER_MPEG1 : i == 1 ? VER_MPEG2 : i == 2 ? VER_MPEG25 : 1, 1, 0);
			write_length(file_q.size());
			send_file();
			build_file(i == 0 ? VER_MPEG1 : i == 1 ? VER_MPEG2 : i == 2 ? VER_MPEG25 : 1, 0, 0);
			write_length(32'hffffffff);
			send_file();
		end
	endtask

	task automatic test_id3_and_tags();
		for (int k = 0; k < 4; k++) begin
			build_file(-1, k, 1);
			write_length(k == 3 ? 32'h1000 : file_q.size());
			send_file();
		end
		build_file(VER_MPEG1, 1, 0);
		write_length(file_q.size() - 5);
		send_file();
	endtask

	task automatic test_back_to_back();
		calm = 1;
		build_file(VER_MPEG1, 2, 0);
		write_length(file_q.size() + 500);
		repeat (6) begin
			build_file(-1, $urandom_range(0, 3), $urandom_range(0, 1));
			send_file();
		end
		calm = 0;
	endtask

	task automatic test_random(int nbytes);
		int sent, fifo_run;
		sent = 0;
		while (sent < nbytes) begin
			build_file(-1, $urandom_range(0, 9) < 6 ? $urandom_range(1, 2) : $urandom_range(0, 3),
				$urandom_range(0, 3) == 0);
			fifo_run = $urandom_range(0, 3);
			if (fifo_run == 0) write_length(pick_length(file_q.size()));
			calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 40)) file_q.push_back(8'($urandom));
			sent += file_q.size();
			send_file();
		end
		calm = 0;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			pop <= 1'b0;
			stall_left--;
		end else begin
			pop <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 3);
		end
	end

	// check each result transaction against the oldest estimate
	always @(posedge clk) begin
		estimate_t e;
		if (arst_n && pop && !empty) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result transaction", 1, 0);
			end else begin
				e = pending_q.pop_front();
				if (play_secs !== e.duration)
					report_mismatch("play_secs", play_secs, e.duration);
				if (frame_found !== e.found) report_mismatch("frame_found", frame_found, e.found);
				if (from_xing !== e.xing) report_mismatch("from_xing", from_xing, e.xing);
			end
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		push = 0;
		data_byte = 0;
		last_byte = 0;
		pop = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		errors = 0;
		calm = 0;
		stall_left = 0;
		len_reg = 0;
		clear_file_state();
		repeat (5) @(negedge clk);
		arst_n = 1;
		test_short_files();
		test_header_variants();
		test_id3_and_tags();
		test_back_to_back();
		test_random(750);
		write_length(32'h0);
		wait_drained();
		if (pending_q.size() == 0 && errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
sv/msde_pkg.sv
sv/msde_front.sv
sv/msde_queue.sv
sv/msde_back.sv
sv/mp3_stream_duration_estimator.sv
sv/msde_checker.sv
dv/tb_mp3_stream_duration_estimator.sv
